// ----- sv/ttm_pkg.sv -----
package ttm_pkg;

   localparam int unsigned INPUT_CLOCK_HZ = 1193182;

   localparam int CNT_W   = 64;
   localparam int RATE_W  = 21;
   localparam int DIV_W   = 16;
   localparam int MSF_W   = 10;
   localparam int ACT_W   = 2;
   localparam int SHORT_W = 32;
   localparam int PROD_W  = SHORT_W + RATE_W;
   localparam int R125_W  = 7;

   localparam int DIV_BITS_PER_CYCLE = 2;
   localparam int DIV_FULL_CYCLES    = CNT_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_SHORT_CYCLES   = SHORT_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = $clog2(DIV_FULL_CYCLES);

   localparam logic [SHORT_W-1:0] CLOCK_HZ        = SHORT_W'(INPUT_CLOCK_HZ);
   localparam logic [RATE_W-1:0]  DEFAULT_RATE_HZ = RATE_W'(1000);
   localparam logic [DIV_W-1:0]   DIV_MAX         = 16'hFFFF;
   localparam logic [RATE_W-1:0]  FIVE_CUBED      = RATE_W'(125);

   localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ARM  = 2'd1;

   typedef enum logic [2:0] {
      DS_CFG_DIVISOR,
      DS_CFG_RATE,
      DS_CFG_GCD5,
      DS_CFG_REDUCE,
      DS_ARM_QUOT,
      DS_ARM_CEIL,
      DS_EL_QUOT,
      DS_EL_FRAC
   } div_src_type;

   typedef enum logic [2:0] {
      MS_ARM_LO,
      MS_ARM_HI,
      MS_ARM_REM,
      MS_EL_LO,
      MS_EL_HI,
      MS_EL_REM
   } mul_src_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_COUNT_PLUS,
      ACC_PROD,
      ACC_ADD_HI
   } acc_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_C_LD1, ST_C_DV1, ST_C_LD2, ST_C_DV2, ST_C_LD3, ST_C_DV3, ST_C_LD4, ST_C_DV4,
      ST_C_FIN,
      ST_A_LD1, ST_A_DV1, ST_A_M0, ST_A_M1, ST_A_M2, ST_A_LD2, ST_A_DV2, ST_A_FIN,
      ST_E_LD1, ST_E_DV1, ST_E_M0, ST_E_M1, ST_E_M2, ST_E_LD2, ST_E_DV2, ST_E_FIN
   } ctrl_state_type;

   typedef struct packed {
      logic        accept;
      logic        div_start;
      div_src_type div_src;
      mul_src_type mul_src;
      acc_op_type  acc_op;
      logic        set_divisor;
      logic        set_rate;
      logic        set_ms_factor;
      logic        set_rate_factor;
      logic        set_deadline;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic in_arm;
      logic out_free;
   } stat_type;

endpackage

// ----- sv/ttm_div.sv -----
module ttm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          short_op,
   input  logic [ttm_pkg::CNT_W-1:0]     dividend,
   input  logic [ttm_pkg::RATE_W-1:0]    divisor,
   output logic [ttm_pkg::CNT_W-1:0]     quotient,
   output logic [ttm_pkg::RATE_W-1:0]    remainder,
   output logic                          busy,
   output logic                          done
);

   logic                             busy_ff, busy_in;
   logic [ttm_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ttm_pkg::CNT_W-1:0]        quo_ff, quo_in;
   logic [ttm_pkg::RATE_W-1:0]       rem_ff, rem_in;
   logic [ttm_pkg::RATE_W-1:0]       dvs_ff, dvs_in;

   // radix-4: two restoring steps per cycle
   always_comb begin
      logic [ttm_pkg::CNT_W-1:0]  q;
      logic [ttm_pkg::RATE_W-1:0] r;
      logic [ttm_pkg::RATE_W:0]   sh;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q       = quo_ff;
      r       = rem_ff;
      sh      = '0;
      if (start) begin
         busy_in = 1'b1;
         dvs_in  = divisor;
         rem_in  = '0;
         if (short_op) begin
            quo_in = {dividend[ttm_pkg::SHORT_W-1:0], {(ttm_pkg::CNT_W-ttm_pkg::SHORT_W){1'b0}}};
            cnt_in = ttm_pkg::DIV_CNT_W'(ttm_pkg::DIV_SHORT_CYCLES - 1);
         end else begin
            quo_in = dividend;
            cnt_in = ttm_pkg::DIV_CNT_W'(ttm_pkg::DIV_FULL_CYCLES - 1);
         end
      end else if (busy_ff) begin
         for (int i = 0; i < ttm_pkg::DIV_BITS_PER_CYCLE; i++) begin
            sh = {r, q[ttm_pkg::CNT_W-1]};
            q  = {q[ttm_pkg::CNT_W-2:0], 1'b0};
            if (sh >= {1'b0, dvs_ff}) begin
               sh   = sh - {1'b0, dvs_ff};
               q[0] = 1'b1;
            end
            r = sh[ttm_pkg::RATE_W-1:0];
         end
         quo_in = q;
         rem_in = r;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign busy      = busy_ff;
   assign done      = busy_ff && (cnt_ff == '0);

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done && (dvs_ff != '0) |=> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

endmodule

// ----- sv/ttm_dp.sv -----
module ttm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ttm_pkg::cmd_type              cmd,
   output ttm_pkg::stat_type             stat,
   input  logic                          csr_wr_en,
   input  logic [ttm_pkg::RATE_W-1:0]    csr_requested_rate_hz,
   input  logic [ttm_pkg::ACT_W-1:0]     req_action,
   input  logic [ttm_pkg::CNT_W-1:0]     req_duration_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ttm_pkg::CNT_W-1:0]     rsp_tick_count,
   output logic [ttm_pkg::CNT_W-1:0]     rsp_elapsed_ms,
   output logic                          rsp_deadline_reached,
   output logic [ttm_pkg::DIV_W-1:0]     rsp_reload_divisor,
   output logic [ttm_pkg::RATE_W-1:0]    rsp_achieved_rate_hz
);

   logic [ttm_pkg::RATE_W-1:0]  req_rate_ff, req_rate_in;
   logic [ttm_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [ttm_pkg::CNT_W-1:0]   deadline_ff, deadline_in;
   logic [ttm_pkg::CNT_W-1:0]   ms_ff, ms_in;
   logic [ttm_pkg::DIV_W-1:0]   divisor_ff, divisor_in;
   logic [ttm_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic [ttm_pkg::MSF_W-1:0]   msf_ff, msf_in;
   logic [ttm_pkg::RATE_W-1:0]  ratef_ff, ratef_in;
   logic [ttm_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [ttm_pkg::CNT_W-1:0]   acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ttm_pkg::CNT_W-1:0]   out_count_ff, out_count_in;
   logic [ttm_pkg::CNT_W-1:0]   out_elapsed_ff, out_elapsed_in;
   logic                        out_reached_ff, out_reached_in;
   logic [ttm_pkg::DIV_W-1:0]   out_divisor_ff, out_divisor_in;
   logic [ttm_pkg::RATE_W-1:0]  out_rate_ff, out_rate_in;

   logic                        div_short;
   logic [ttm_pkg::CNT_W-1:0]   div_dividend;
   logic [ttm_pkg::RATE_W-1:0]  div_divisor;
   logic [ttm_pkg::CNT_W-1:0]   div_quo;
   logic [ttm_pkg::RATE_W-1:0]  div_rem;
   logic                        div_busy;
   logic                        div_done;

   logic [ttm_pkg::RATE_W-1:0]  hz;
   logic [ttm_pkg::SHORT_W-1:0] rounded_clock;
   logic [ttm_pkg::DIV_W-1:0]   divisor_clamped;
   logic [ttm_pkg::RATE_W-1:0]  rate_calc;
   logic [1:0]                  e2;
   logic [1:0]                  e5;
   logic [ttm_pkg::R125_W-1:0]  r125;
   logic [14:0]                 r125_x205;
   logic [4:0]                  r125_div5;
   logic                        mult5;
   logic                        mult25;
   logic [ttm_pkg::RATE_W-1:0]  p5;
   logic [ttm_pkg::MSF_W-1:0]   msf_base;
   logic [ttm_pkg::MSF_W-1:0]   msf_calc;
   logic [ttm_pkg::SHORT_W-1:0] mul_a;
   logic [ttm_pkg::RATE_W-1:0]  mul_b;
   logic [ttm_pkg::CNT_W-1:0]   sum_fin;

   ttm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .short_op  (div_short),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .busy      (div_busy),
      .done      (div_done)
   );

   // divisor = round(clock / hz), clamped
   assign hz            = (req_rate_ff == '0) ? ttm_pkg::DEFAULT_RATE_HZ : req_rate_ff;
   assign rounded_clock = ttm_pkg::CLOCK_HZ + ttm_pkg::SHORT_W'(hz >> 1);

   always_comb begin
      if (div_quo == '0) begin
         divisor_clamped = ttm_pkg::DIV_W'(1);
      end else if (|div_quo[ttm_pkg::CNT_W-1:ttm_pkg::DIV_W]) begin
         divisor_clamped = ttm_pkg::DIV_MAX;
      end else begin
         divisor_clamped = div_quo[ttm_pkg::DIV_W-1:0];
      end
   end

   assign rate_calc = (div_quo == '0) ? ttm_pkg::RATE_W'(1) : div_quo[ttm_pkg::RATE_W-1:0];

   // gcd(rate, 1000) = 2^e2 * 5^e5
   always_comb begin
      priority if (rate_ff[0]) begin
         e2 = 2'd0;
      end else if (rate_ff[1]) begin
         e2 = 2'd1;
      end else if (rate_ff[2]) begin
         e2 = 2'd2;
      end else begin
         e2 = 2'd3;
      end
   end

   // r125 = rate mod 125; divide by 5 via multiply by 205/1024
   assign r125      = div_rem[ttm_pkg::R125_W-1:0];
   assign r125_x205 = 15'(r125) * 15'd205;
   assign r125_div5 = r125_x205[14:10];
   assign mult5     = ({2'b00, r125_div5} + {r125_div5, 2'b00}) == r125;
   assign mult25    = (r125 == 7'd25) || (r125 == 7'd50) || (r125 == 7'd75) ||
                      (r125 == 7'd100);

   always_comb begin
      priority if (r125 == '0) begin
         e5 = 2'd3;
      end else if (mult25) begin
         e5 = 2'd2;
      end else if (mult5) begin
         e5 = 2'd1;
      end else begin
         e5 = 2'd0;
      end
   end

   always_comb begin
      unique case (e5)
         2'd0: begin
            p5       = ttm_pkg::RATE_W'(1);
            msf_base = ttm_pkg::MSF_W'(125);
         end
         2'd1: begin
            p5       = ttm_pkg::RATE_W'(5);
            msf_base = ttm_pkg::MSF_W'(25);
         end
         2'd2: begin
            p5       = ttm_pkg::RATE_W'(25);
            msf_base = ttm_pkg::MSF_W'(5);
         end
         default: begin
            p5       = ttm_pkg::FIVE_CUBED;
            msf_base = ttm_pkg::MSF_W'(1);
         end
      endcase
   end

   assign msf_calc = ttm_pkg::MSF_W'(msf_base << (2'd3 - e2));

   always_comb begin
      div_short    = 1'b1;
      div_dividend = '0;
      div_divisor  = ratef_ff;
      unique case (cmd.div_src)
         ttm_pkg::DS_CFG_DIVISOR: begin
            div_dividend = ttm_pkg::CNT_W'(rounded_clock);
            div_divisor  = hz;
         end
         ttm_pkg::DS_CFG_RATE: begin
            div_dividend = ttm_pkg::CNT_W'(ttm_pkg::CLOCK_HZ);
            div_divisor  = ttm_pkg::RATE_W'(divisor_clamped);
         end
         ttm_pkg::DS_CFG_GCD5: begin
            div_dividend = ttm_pkg::CNT_W'(rate_calc);
            div_divisor  = ttm_pkg::FIVE_CUBED;
         end
         ttm_pkg::DS_CFG_REDUCE: begin
            div_dividend = ttm_pkg::CNT_W'(rate_ff >> e2);
            div_divisor  = p5;
         end
         ttm_pkg::DS_ARM_QUOT: begin
            div_short    = 1'b0;
            div_dividend = ms_ff;
            div_divisor  = ttm_pkg::RATE_W'(msf_ff);
         end
         ttm_pkg::DS_ARM_CEIL: begin
            div_dividend = ttm_pkg::CNT_W'(prod_ff[ttm_pkg::SHORT_W-1:0] +
                           ttm_pkg::SHORT_W'(msf_ff) - 1'b1);
            div_divisor  = ttm_pkg::RATE_W'(msf_ff);
         end
         ttm_pkg::DS_EL_QUOT: begin
            div_short    = 1'b0;
            div_dividend = count_ff;
            div_divisor  = ratef_ff;
         end
         ttm_pkg::DS_EL_FRAC: begin
            div_dividend = ttm_pkg::CNT_W'(prod_ff[ttm_pkg::SHORT_W-1:0]);
            div_divisor  = ratef_ff;
         end
      endcase
   end

   always_comb begin
      mul_a = div_quo[ttm_pkg::SHORT_W-1:0];
      mul_b = ratef_ff;
      unique case (cmd.mul_src)
         ttm_pkg::MS_ARM_LO: begin
            mul_a = div_quo[ttm_pkg::SHORT_W-1:0];
            mul_b = ratef_ff;
         end
         ttm_pkg::MS_ARM_HI: begin
            mul_a = div_quo[ttm_pkg::CNT_W-1:ttm_pkg::SHORT_W];
            mul_b = ratef_ff;
         end
         ttm_pkg::MS_ARM_REM: begin
            mul_a = ttm_pkg::SHORT_W'(div_rem);
            mul_b = ratef_ff;
         end
         ttm_pkg::MS_EL_LO: begin
            mul_a = div_quo[ttm_pkg::SHORT_W-1:0];
            mul_b = ttm_pkg::RATE_W'(msf_ff);
         end
         ttm_pkg::MS_EL_HI: begin
            mul_a = div_quo[ttm_pkg::CNT_W-1:ttm_pkg::SHORT_W];
            mul_b = ttm_pkg::RATE_W'(msf_ff);
         end
         ttm_pkg::MS_EL_REM: begin
            mul_a = ttm_pkg::SHORT_W'(div_rem);
            mul_b = ttm_pkg::RATE_W'(msf_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = ttm_pkg::PROD_W'(mul_a) * ttm_pkg::PROD_W'(mul_b);
   assign sum_fin = acc_ff + div_quo;

   always_comb begin
      unique case (cmd.acc_op)
         ttm_pkg::ACC_HOLD:       acc_in = acc_ff;
         ttm_pkg::ACC_COUNT_PLUS: acc_in = count_ff + ttm_pkg::CNT_W'(prod_ff);
         ttm_pkg::ACC_PROD:       acc_in = ttm_pkg::CNT_W'(prod_ff);
         ttm_pkg::ACC_ADD_HI: begin
            acc_in = acc_ff + {prod_ff[ttm_pkg::SHORT_W-1:0],
                               {(ttm_pkg::CNT_W-ttm_pkg::SHORT_W){1'b0}}};
         end
      endcase
   end

   always_comb begin
      req_rate_in    = csr_wr_en ? csr_requested_rate_hz : req_rate_ff;
      count_in       = count_ff;
      ms_in          = ms_ff;
      if (cmd.accept) begin
         ms_in = req_duration_ms;
         if (req_action == ttm_pkg::ACT_TICK) begin
            count_in = count_ff + 1'b1;
         end
      end
      deadline_in    = cmd.set_deadline    ? sum_fin                          : deadline_ff;
      divisor_in     = cmd.set_divisor     ? divisor_clamped                  : divisor_ff;
      rate_in        = cmd.set_rate        ? rate_calc                        : rate_ff;
      msf_in         = cmd.set_ms_factor   ? msf_calc                         : msf_ff;
      ratef_in       = cmd.set_rate_factor ? div_quo[ttm_pkg::RATE_W-1:0]     : ratef_ff;
      rsp_valid_in   = cmd.out_load || (rsp_valid_ff && !rsp_ready);
      out_count_in   = cmd.out_load ? count_ff                 : out_count_ff;
      out_elapsed_in = cmd.out_load ? sum_fin                  : out_elapsed_ff;
      out_reached_in = cmd.out_load ? (count_ff >= deadline_ff) : out_reached_ff;
      out_divisor_in = cmd.out_load ? divisor_ff               : out_divisor_ff;
      out_rate_in    = cmd.out_load ? rate_ff                  : out_rate_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_rate_ff  <= ttm_pkg::DEFAULT_RATE_HZ;
         count_ff     <= '0;
         deadline_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_rate_ff  <= req_rate_in;
         count_ff     <= count_in;
         deadline_ff  <= deadline_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ms_ff          <= ms_in;
      divisor_ff     <= divisor_in;
      rate_ff        <= rate_in;
      msf_ff         <= msf_in;
      ratef_ff       <= ratef_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      out_count_ff   <= out_count_in;
      out_elapsed_ff <= out_elapsed_in;
      out_reached_ff <= out_reached_in;
      out_divisor_ff <= out_divisor_in;
      out_rate_ff    <= out_rate_in;
   end

   assign stat.div_busy = div_busy;
   assign stat.div_done = div_done;
   assign stat.in_arm   = (req_action == ttm_pkg::ACT_ARM);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_tick_count       = out_count_ff;
   assign rsp_elapsed_ms       = out_elapsed_ff;
   assign rsp_deadline_reached = out_reached_ff;
   assign rsp_reload_divisor   = out_divisor_ff;
   assign rsp_achieved_rate_hz = out_rate_ff;

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && (req_action == ttm_pkg::ACT_TICK) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("tick word did not advance the count");

endmodule

// ----- sv/ttm_ctrl.sv -----
module ttm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               req_valid,
   output logic               req_ready,
   input  ttm_pkg::stat_type  stat,
   output ttm_pkg::cmd_type   cmd
);

   ttm_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      if (csr_wr_en) begin
         state_in = ttm_pkg::ST_C_LD1;
      end else begin
         unique case (state_ff)
            ttm_pkg::ST_IDLE: begin
               if (req_valid) begin
                  state_in = stat.in_arm ? ttm_pkg::ST_A_LD1 : ttm_pkg::ST_E_LD1;
               end
            end
            ttm_pkg::ST_C_LD1: state_in = ttm_pkg::ST_C_DV1;
            ttm_pkg::ST_C_DV1: if (stat.div_done) state_in = ttm_pkg::ST_C_LD2;
            ttm_pkg::ST_C_LD2: state_in = ttm_pkg::ST_C_DV2;
            ttm_pkg::ST_C_DV2: if (stat.div_done) state_in = ttm_pkg::ST_C_LD3;
            ttm_pkg::ST_C_LD3: state_in = ttm_pkg::ST_C_DV3;
            ttm_pkg::ST_C_DV3: if (stat.div_done) state_in = ttm_pkg::ST_C_LD4;
            ttm_pkg::ST_C_LD4: state_in = ttm_pkg::ST_C_DV4;
            ttm_pkg::ST_C_DV4: if (stat.div_done) state_in = ttm_pkg::ST_C_FIN;
            ttm_pkg::ST_C_FIN: state_in = ttm_pkg::ST_IDLE;
            ttm_pkg::ST_A_LD1: state_in = ttm_pkg::ST_A_DV1;
            ttm_pkg::ST_A_DV1: if (stat.div_done) state_in = ttm_pkg::ST_A_M0;
            ttm_pkg::ST_A_M0:  state_in = ttm_pkg::ST_A_M1;
            ttm_pkg::ST_A_M1:  state_in = ttm_pkg::ST_A_M2;
            ttm_pkg::ST_A_M2:  state_in = ttm_pkg::ST_A_LD2;
            ttm_pkg::ST_A_LD2: state_in = ttm_pkg::ST_A_DV2;
            ttm_pkg::ST_A_DV2: if (stat.div_done) state_in = ttm_pkg::ST_A_FIN;
            ttm_pkg::ST_A_FIN: state_in = ttm_pkg::ST_E_LD1;
            ttm_pkg::ST_E_LD1: state_in = ttm_pkg::ST_E_DV1;
            ttm_pkg::ST_E_DV1: if (stat.div_done) state_in = ttm_pkg::ST_E_M0;
            ttm_pkg::ST_E_M0:  state_in = ttm_pkg::ST_E_M1;
            ttm_pkg::ST_E_M1:  state_in = ttm_pkg::ST_E_M2;
            ttm_pkg::ST_E_M2:  state_in = ttm_pkg::ST_E_LD2;
            ttm_pkg::ST_E_LD2: state_in = ttm_pkg::ST_E_DV2;
            ttm_pkg::ST_E_DV2: if (stat.div_done) state_in = ttm_pkg::ST_E_FIN;
            ttm_pkg::ST_E_FIN: if (stat.out_free) state_in = ttm_pkg::ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ttm_pkg::ST_IDLE: begin
            req_ready  = !csr_wr_en;
            cmd.accept = req_valid && !csr_wr_en;
         end
         ttm_pkg::ST_C_LD1: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = ttm_pkg::DS_CFG_DIVISOR;
         end
         ttm_pkg::ST_C_LD2: begin
            cmd.set_divisor = 1'b1;
            cmd.div_start   = 1'b1;
            cmd.div_src     = ttm_pkg::DS_CFG_RATE;
         end
         ttm_pkg::ST_C_LD3: begin
            cmd.set_rate  = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_src   = ttm_pkg::DS_CFG_GCD5;
         end
         ttm_pkg::ST_C_LD4: begin
            cmd.set_ms_factor = 1'b1;
            cmd.div_start     = 1'b1;
            cmd.div_src       = ttm_pkg::DS_CFG_REDUCE;
         end
         ttm_pkg::ST_C_FIN: cmd.set_rate_factor = 1'b1;
         ttm_pkg::ST_A_LD1: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = ttm_pkg::DS_ARM_QUOT;
         end
         ttm_pkg::ST_A_M0: cmd.mul_src = ttm_pkg::MS_ARM_LO;
         ttm_pkg::ST_A_M1: begin
            cmd.mul_src = ttm_pkg::MS_ARM_HI;
            cmd.acc_op  = ttm_pkg::ACC_COUNT_PLUS;
         end
         ttm_pkg::ST_A_M2: begin
            cmd.mul_src = ttm_pkg::MS_ARM_REM;
            cmd.acc_op  = ttm_pkg::ACC_ADD_HI;
         end
         ttm_pkg::ST_A_LD2: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = ttm_pkg::DS_ARM_CEIL;
         end
         ttm_pkg::ST_A_FIN: cmd.set_deadline = 1'b1;
         ttm_pkg::ST_E_LD1: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = ttm_pkg::DS_EL_QUOT;
         end
         ttm_pkg::ST_E_M0: cmd.mul_src = ttm_pkg::MS_EL_LO;
         ttm_pkg::ST_E_M1: begin
            cmd.mul_src = ttm_pkg::MS_EL_HI;
            cmd.acc_op  = ttm_pkg::ACC_PROD;
         end
         ttm_pkg::ST_E_M2: begin
            cmd.mul_src = ttm_pkg::MS_EL_REM;
            cmd.acc_op  = ttm_pkg::ACC_ADD_HI;
         end
         ttm_pkg::ST_E_LD2: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = ttm_pkg::DS_EL_FRAC;
         end
         ttm_pkg::ST_E_FIN: cmd.out_load = stat.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   // reset starts with a rate recompute from the default request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttm_pkg::ST_C_LD1;
      end else begin
         state_ff <= state_in;
      end
   end

   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stat.div_busy)
      else $error("accepting a word while the divider is busy");

   a_start_runs_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> stat.div_busy)
      else $error("divider did not start");

endmodule

// ----- sv/tick_timebase_ms_converter.sv -----
// Tick timebase with millisecond conversion. A write on csr_wr_en sets the requested
// tick rate (zero means 1000 Hz) and starts a recompute of the reload divisor, the
// achieved rate and the reduced ms/rate factors; the same recompute runs after reset,
// with req_ready low meanwhile. Each request word (tick, arm or status) yields one
// response word, unless a csr_wr_en write restarts the recompute before it is loaded.
// A new word is accepted only after the last one's divides and multiplies are done;
// the pace is set by a shared radix-4 divider (64-bit and 32-bit quotients) that each
// word uses two or four times, plus a 32x21 multiplier pass per partial product. The
// response sits in an output register, so the next word is accepted while a finished
// response waits on rsp_ready.
module tick_timebase_ms_converter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ttm_pkg::RATE_W-1:0]    csr_requested_rate_hz,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ttm_pkg::ACT_W-1:0]     req_action,
   input  logic [ttm_pkg::CNT_W-1:0]     req_duration_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ttm_pkg::CNT_W-1:0]     rsp_tick_count,
   output logic [ttm_pkg::CNT_W-1:0]     rsp_elapsed_ms,
   output logic                          rsp_deadline_reached,
   output logic [ttm_pkg::DIV_W-1:0]     rsp_reload_divisor,
   output logic [ttm_pkg::RATE_W-1:0]    rsp_achieved_rate_hz
);

   ttm_pkg::cmd_type  cmd;
   ttm_pkg::stat_type stat;

   ttm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttm_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_wr_en             (csr_wr_en),
      .csr_requested_rate_hz (csr_requested_rate_hz),
      .req_action            (req_action),
      .req_duration_ms       (req_duration_ms),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_tick_count        (rsp_tick_count),
      .rsp_elapsed_ms        (rsp_elapsed_ms),
      .rsp_deadline_reached  (rsp_deadline_reached),
      .rsp_reload_divisor    (rsp_reload_divisor),
      .rsp_achieved_rate_hz  (rsp_achieved_rate_hz)
   );

endmodule
